/* sv/binary64_round_pack_nearest_even_unit_assert.svh */
// Assertion macros for the binary64 round-and-pack unit
`ifndef BINARY64_ROUND_PACK_NEAREST_EVEN_UNIT_ASSERT_SVH
`define BINARY64_ROUND_PACK_NEAREST_EVEN_UNIT_ASSERT_SVH
// implication checked on every clock edge outside reset (i_clk, i_rst_n in scope)
`define RPNE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define RPNE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* sv/rpne_pkg.sv */
// Package: shared types and constants for the round-and-pack unit
package rpne_pkg;
    localparam int unsigned ExpW = 13;
    localparam int unsigned SigW = 63;
    localparam int unsigned RndBits = 10;
    localparam logic [9:0] RndHalf = 10'h200;

    // request payload
    typedef struct packed {
        logic                   sign_bit;
        logic signed [ExpW-1:0] biased_exponent;
        logic [SigW-1:0]        significand;
    } t_req;

    // after the subnormal shift
    typedef struct packed {
        logic            sgn;
        logic [ExpW-1:0] expo;
        logic [SigW-1:0] sig;
    } t_shf;

    // after rounding
    typedef struct packed {
        logic        sgn;
        logic [ExpW-1:0] expo;
        logic [53:0] sig;
    } t_rnd;
endpackage

/* sv/rpne_if.sv */
// Valid/ready channel interface
interface rpne_if #(parameter int unsigned W = 64);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* sv/binary64_round_pack_nearest_even_unit.sv */
// Top level: binary64 round-to-nearest-even and pack pipeline
// Three register stages (shift, round, pack); an accepted request is offered
// on the output once it has passed all three, in that order.
// Throughput: one request per cycle unless stalled; each stage holds one.
// A stall at the output freezes all stages together and drops input ready.
// Reset (synchronous, active low) clears the stage valid bits only.
module binary64_round_pack_nearest_even_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    rpne_if.sink   i_req,
    rpne_if.source o_rsp
);
    logic           w_en;
    logic           w_v1, w_v2;
    rpne_pkg::t_req w_req;
    rpne_pkg::t_shf w_shf;
    rpne_pkg::t_rnd w_rnd;

    // pipeline advances unless the output holds an untaken result
    assign w_en        = o_rsp.ready || !o_rsp.valid;
    assign i_req.ready = w_en;
    assign w_req       = i_req.data;

    rpne_shift u_shift (.i_clk, .i_rst_n, .i_en(w_en), .i_vld(i_req.valid),
        .i_req(w_req), .o_vld(w_v1), .o_shf(w_shf));
    rpne_round u_round (.i_clk, .i_rst_n, .i_en(w_en), .i_vld(w_v1),
        .i_shf(w_shf), .o_vld(w_v2), .o_rnd(w_rnd));
    rpne_pack u_pack (.i_clk, .i_rst_n, .i_en(w_en), .i_vld(w_v2),
        .i_rnd(w_rnd), .o_vld(o_rsp.valid), .o_word(o_rsp.data));
endmodule

/* sv/rpne_shift.sv */
// Stage 1: subnormal right shift with sticky jam
module rpne_shift (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  rpne_pkg::t_req   i_req,
    output logic             o_vld,
    output rpne_pkg::t_shf   o_shf
);
    logic [12:0] w_mag;
    logic [62:0] w_sig;
    logic [125:0] w_wide;
    logic        r_vld;
    rpne_pkg::t_shf r_shf;

    // magnitude of negative exponent; shift of 63 or more keeps only sticky
    always_comb begin
        w_mag  = 13'd0 - $unsigned(i_req.biased_exponent);
        w_wide = {i_req.significand, 63'd0} >> w_mag[5:0];
        if (!i_req.biased_exponent[12]) begin
            w_sig = i_req.significand;
        end else if (w_mag >= 13'd63) begin
            w_sig = {62'd0, |i_req.significand};
        end else begin
            w_sig = w_wide[125:63] | {62'd0, |w_wide[62:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_shf.sgn  <= i_req.sign_bit;
            r_shf.expo <= i_req.biased_exponent[12] ? 13'd0 : $unsigned(i_req.biased_exponent);
            r_shf.sig  <= w_sig;
        end
    end

    assign o_vld = r_vld;
    assign o_shf = r_shf;
endmodule

/* sv/rpne_round.sv */
// Stage 2: add half, drop guard bits, clear lsb on tie
module rpne_round (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  rpne_pkg::t_shf   i_shf,
    output logic             o_vld,
    output rpne_pkg::t_rnd   o_rnd
);
    logic [63:0] w_sum;
    logic [53:0] w_sig;
    logic        r_vld;
    rpne_pkg::t_rnd r_rnd;

    always_comb begin
        w_sum = {1'b0, i_shf.sig} + {54'd0, rpne_pkg::RndHalf};
        w_sig = w_sum[63:rpne_pkg::RndBits];
        if (i_shf.sig[9:0] == rpne_pkg::RndHalf) begin
            w_sig[0] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rnd.sgn  <= i_shf.sgn;
            r_rnd.expo <= (w_sig == 54'd0) ? 13'd0 : i_shf.expo;
            r_rnd.sig  <= w_sig;
        end
    end

    assign o_vld = r_vld;
    assign o_rnd = r_rnd;
endmodule

/* sv/rpne_pack.sv */
// Stage 3: pack sign, exponent and significand modulo 2^64
module rpne_pack (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  rpne_pkg::t_rnd   i_rnd,
    output logic             o_vld,
    output logic [63:0]      o_word
);
    logic [63:0] w_word;
    logic        r_vld;
    logic [63:0] r_word;

    // carry out of the significand runs into exponent, exponent into sign
    // (exponent bit 12 lands above bit 63 and drops out)
    assign w_word = {i_rnd.sgn, 63'd0} + {i_rnd.expo[11:0], 52'd0} + {10'd0, i_rnd.sig};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= w_word;
        end
    end

    assign o_vld  = r_vld;
    assign o_word = r_word;
endmodule

/* sv/rpne_checker.sv */
// Port checker for the round-and-pack unit, bound to the top level
`include "binary64_round_pack_nearest_even_unit_assert.svh"
module rpne_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_out_data
);
    // stalled result holds
    `RPNE_ASSERT_NXT(a_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data))
    // input is ready whenever output is free
    `RPNE_ASSERT_IMP(a_rdy, !i_out_valid || i_out_ready, i_in_ready)
    // a stalled output blocks intake
    `RPNE_ASSERT_IMP(a_blk, i_out_valid && !i_out_ready, !i_in_ready)
    // accepted request comes out of the pack stage when no stall intervenes
    `RPNE_ASSERT_IMP(a_lat, i_in_valid && i_in_ready ##1 i_in_ready ##1 i_in_ready, ##1 i_out_valid)
endmodule

bind binary64_round_pack_nearest_even_unit rpne_checker u_rpne_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(i_req.valid), .i_in_ready(i_req.ready),
    .i_out_valid(o_rsp.valid), .i_out_ready(o_rsp.ready),
    .i_out_data(o_rsp.data)
);
